>>> rtl/core/assert_macros.svh
// assertion helpers, compiled out when ASSERT_OFF is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/sgf_pkg.sv
package sgf_pkg;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_PULL   = 2'd2,
        MODE_RECOIL = 2'd3
    } mode_t;

    localparam logic CFG_RADIUS = 1'b0;
    localparam logic CFG_ACCEL  = 1'b1;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [39:0]        MASS_SUM_MAX = '1;
    localparam logic [63:0]        FORCE_MAX = 64'h0000_7FFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [23:0]        item_mass;
    } item_t;

    typedef struct packed {
        logic signed [47:0] force_x;
        logic signed [47:0] force_y;
        logic signed [47:0] force_z;
        logic               applied;
    } result_t;

    // saturating signed 64-bit add
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        begin
            s = {a[63], a} + {b[63], b};
            if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF)
                sat_add = S64_MAX;
            else if (s < 65'sh1_8000_0000_0000_0000)
                sat_add = S64_MIN;
            else
                sat_add = s[63:0];
        end
    endfunction

    // magnitude plus sign to saturated 48-bit force
    function automatic logic signed [47:0] sat_force(input logic [63:0] m, input logic neg);
        logic signed [47:0] f;
        begin
            if (m > FORCE_MAX)
                f = neg ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
            else
                f = neg ? -$signed(m[47:0]) : $signed(m[47:0]);
            sat_force = f;
        end
    endfunction

endpackage

>>> rtl/core/sphere_gravity_force_with_recoil.sv
// work per item: clear needs no unit operation, add source and recoil share run one per axis,
// pull target at most three center-of-mass divides, three squares, square root, two scaling
// divides (only outside the radius), one multiply and three force divides
// throughput: one item at a time; every multiply and divide runs on one shared shift-add
// multiplier and restoring divider (32 multiply steps, 64 divide steps per operation)
// reset: asynchronous active low; clears configuration, accumulators, result and the sequencer
`include "assert_macros.svh"

module sphere_gravity_force_with_recoil import sgf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_MCHK, S_DIV, S_SQRT, S_POST, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        ST_MOM, ST_COM, ST_SQ, ST_T1, ST_T2, ST_TM, ST_F, ST_REC
    } step_t;

    typedef struct packed {
        logic [63:0] a;
        logic [31:0] b;
        logic [63:0] c;
        logic        div;
        step_t       step;
    } op_t;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] axis_reg, axis_next;

    logic [63:0] a_reg, a_next;
    logic [63:0] c_reg, c_next;
    logic [95:0] p_reg, p_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] lo_reg, lo_next;
    logic [63:0] bit_reg, bit_next;
    logic        div_reg, div_next;

    logic [31:0]        radius_reg;
    logic signed [31:0] accel_reg;
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] pos_next [3];
    logic [23:0]        m_reg, m_next;
    logic signed [31:0] off_reg [3];
    logic signed [31:0] off_next [3];
    logic [63:0]        d2_reg, d2_next;
    logic [31:0]        d_reg, d_next;
    logic               inside_reg, inside_next;
    logic [63:0]        sm_reg, sm_next;
    logic signed [63:0] mom_reg [3];
    logic signed [63:0] mom_next [3];
    logic signed [63:0] rec_reg [3];
    logic signed [63:0] rec_next [3];
    logic [39:0]        msum_reg, msum_next;
    logic signed [47:0] f_reg [3];
    logic signed [47:0] f_next [3];
    logic               applied_reg, applied_next;

    // shared unit datapath
    logic [64:0] mul_sum;
    logic [63:0] hi_w;
    logic [63:0] rem_sh;
    logic        div_ge;
    logic [63:0] sq_rb;
    logic [63:0] prod_signed;
    logic [63:0] q_lim;
    logic signed [32:0] com_w;
    logic signed [33:0] diff_w;
    logic signed [31:0] off_w;
    logic [40:0] msum_w;
    logic signed [47:0] f_w;
    logic        launch;
    op_t         op;
    logic        disabled;

    assign mul_sum = {1'b0, p_reg[95:32]} + (p_reg[0] ? {1'b0, a_reg} : 65'd0);
    assign hi_w    = {32'd0, p_reg[95:64]};
    assign rem_sh  = {rem_reg[62:0], lo_reg[63]};
    assign div_ge  = rem_reg[63] || (rem_sh >= c_reg);
    assign sq_rb   = lo_reg + bit_reg;

    assign disabled = (radius_reg == '0) || (accel_reg == '0) || (msum_reg == '0);

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = (state_reg == S_OUT);
    assign result.force_x = f_reg[0];
    assign result.force_y = f_reg[1];
    assign result.force_z = f_reg[2];
    assign result.applied = applied_reg;

    // magnitude of a signed 64-bit accumulator
    function automatic logic [63:0] mom_mag_next(input logic signed [63:0] v);
        begin
            mom_mag_next = v[63] ? 64'(-v) : 64'(v);
        end
    endfunction

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        axis_next    = axis_reg;
        a_next       = a_reg;
        c_next       = c_reg;
        p_next       = p_reg;
        rem_next     = rem_reg;
        lo_next      = lo_reg;
        bit_next     = bit_reg;
        div_next     = div_reg;
        pos_next     = pos_reg;
        m_next       = m_reg;
        off_next     = off_reg;
        d2_next      = d2_reg;
        d_next       = d_reg;
        inside_next  = inside_reg;
        sm_next      = sm_reg;
        mom_next     = mom_reg;
        rec_next     = rec_reg;
        msum_next    = msum_reg;
        f_next       = f_reg;
        applied_next = applied_reg;
        launch       = 1'b0;
        op           = '{a: '0, b: '0, c: '0, div: 1'b0, step: ST_MOM};
        prod_signed  = '0;
        q_lim        = '0;
        com_w        = '0;
        diff_w       = '0;
        off_w        = '0;
        msum_w       = '0;
        f_w          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    pos_next[0]  = item.pos_x;
                    pos_next[1]  = item.pos_y;
                    pos_next[2]  = item.pos_z;
                    m_next       = item.item_mass;
                    axis_next    = 2'd0;
                    d2_next      = '0;
                    applied_next = 1'b0;
                    for (int i = 0; i < 3; i++)
                        f_next[i] = '0;
                    state_next = S_OUT;
                    case (mode_t'(item.mode))
                        MODE_CLEAR:
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                mom_next[i] = '0;
                                rec_next[i] = '0;
                            end
                            msum_next = '0;
                        end
                        MODE_ADD:
                        begin
                            launch = 1'b1;
                            op = '{a: {32'd0, (item.pos_x[31] ? 32'(-item.pos_x)
                                                              : 32'(item.pos_x))},
                                   b: {8'd0, item.item_mass}, c: '0, div: 1'b0,
                                   step: ST_MOM};
                        end
                        MODE_PULL:
                        begin
                            if (!disabled && item.item_mass != '0)
                            begin
                                launch = 1'b1;
                                op = '{a: mom_reg[0][63] ? 64'(-mom_reg[0]) : 64'(mom_reg[0]),
                                       b: 32'd1, c: {24'd0, msum_reg}, div: 1'b1,
                                       step: ST_COM};
                            end
                        end
                        MODE_RECOIL:
                        begin
                            if (!disabled && item.item_mass != '0)
                            begin
                                launch = 1'b1;
                                op = '{a: rec_reg[0][63] ? 64'(-rec_reg[0]) : 64'(rec_reg[0]),
                                       b: {8'd0, item.item_mass}, c: {24'd0, msum_reg},
                                       div: 1'b1, step: ST_REC};
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // shift-add multiply, one multiplier bit per cycle
            S_MUL:
            begin
                p_next   = {mul_sum, p_reg[31:1]};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                    state_next = S_MCHK;
            end

            // overflow check before the divide; a multiply-only operation goes straight to its result
            S_MCHK:
            begin
                cnt_next = '0;
                if (!div_reg)
                begin
                    lo_next    = p_reg[63:0];
                    state_next = S_POST;
                end
                else if (c_reg == '0 || hi_w >= c_reg)
                begin
                    lo_next    = '1;
                    state_next = S_POST;
                end
                else
                begin
                    rem_next   = hi_w;
                    lo_next    = p_reg[63:0];
                    state_next = S_DIV;
                end
            end

            // restoring divide, quotient shifts into lo
            S_DIV:
            begin
                rem_next = div_ge ? rem_sh - c_reg : rem_sh;
                lo_next  = {lo_reg[62:0], div_ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = S_POST;
            end

            // bitwise integer square root, x in rem, root in lo
            S_SQRT:
            begin
                if (rem_reg >= sq_rb)
                begin
                    rem_next = rem_reg - sq_rb;
                    lo_next  = (lo_reg >> 1) + bit_reg;
                end
                else
                    lo_next = lo_reg >> 1;
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    d_next      = lo_next[31:0];
                    inside_next = (lo_next[31:0] < radius_reg);
                    axis_next   = 2'd0;
                    launch      = 1'b1;
                    if (lo_next[31:0] < radius_reg)
                        op = '{a: {32'd0, (accel_reg[31] ? 32'(-accel_reg) : 32'(accel_reg))},
                               b: {8'd0, m_reg}, c: '0, div: 1'b0, step: ST_TM};
                    else
                        op = '{a: {32'd0, (accel_reg[31] ? 32'(-accel_reg) : 32'(accel_reg))},
                               b: radius_reg, c: {32'd0, lo_next[31:0]}, div: 1'b1,
                               step: ST_T1};
                end
            end

            // consume a unit result
            S_POST:
            begin
                case (step_reg)
                    ST_MOM:
                    begin
                        prod_signed = pos_reg[axis_reg][31] ? -lo_reg : lo_reg;
                        mom_next[axis_reg] = sat_add(mom_reg[axis_reg], prod_signed);
                        if (axis_reg == 2'd2)
                        begin
                            msum_w = {1'b0, msum_reg} + {17'd0, m_reg};
                            msum_next = msum_w[40] ? MASS_SUM_MAX : msum_w[39:0];
                            state_next = S_OUT;
                        end
                        else
                        begin
                            axis_next = axis_reg + 2'd1;
                            launch = 1'b1;
                            op = '{a: {32'd0, (pos_reg[axis_reg + 2'd1][31]
                                               ? 32'(-pos_reg[axis_reg + 2'd1])
                                               : 32'(pos_reg[axis_reg + 2'd1]))},
                                   b: {8'd0, m_reg}, c: '0, div: 1'b0, step: ST_MOM};
                        end
                    end
                    ST_COM:
                    begin
                        if (mom_reg[axis_reg][63])
                        begin
                            q_lim = (lo_reg > 64'h8000_0000) ? 64'h8000_0000 : lo_reg;
                            com_w = -$signed({1'b0, q_lim[31:0]});
                        end
                        else
                        begin
                            q_lim = (lo_reg > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : lo_reg;
                            com_w = $signed({1'b0, q_lim[31:0]});
                        end
                        diff_w = 34'(pos_reg[axis_reg]) - 34'(com_w);
                        if (diff_w > 34'sh0_7FFF_FFFF)
                            off_w = 32'sh7FFF_FFFF;
                        else if (diff_w < -34'sh0_8000_0000)
                            off_w = 32'sh8000_0000;
                        else
                            off_w = diff_w[31:0];
                        off_next[axis_reg] = off_w;
                        launch = 1'b1;
                        op = '{a: {32'd0, (off_w[31] ? 32'(-off_w) : 32'(off_w))},
                               b: (off_w[31] ? 32'(-off_w) : 32'(off_w)), c: '0, div: 1'b0,
                               step: ST_SQ};
                    end
                    ST_SQ:
                    begin
                        d2_next = d2_reg + lo_reg;
                        if (axis_reg == 2'd2)
                        begin
                            if (d2_next == '0)
                                state_next = S_OUT;
                            else
                            begin
                                rem_next   = d2_next;
                                lo_next    = '0;
                                bit_next   = 64'h4000_0000_0000_0000;
                                cnt_next   = '0;
                                state_next = S_SQRT;
                            end
                        end
                        else
                        begin
                            axis_next = axis_reg + 2'd1;
                            launch = 1'b1;
                            op = '{a: mom_mag_next(mom_reg[axis_reg + 2'd1]), b: 32'd1,
                                   c: {24'd0, msum_reg}, div: 1'b1, step: ST_COM};
                        end
                    end
                    ST_T1:
                    begin
                        launch = 1'b1;
                        op = '{a: lo_reg, b: radius_reg, c: {32'd0, d_reg}, div: 1'b1,
                               step: ST_T2};
                    end
                    ST_T2:
                    begin
                        launch = 1'b1;
                        op = '{a: lo_reg, b: {8'd0, m_reg}, c: '0, div: 1'b0, step: ST_TM};
                    end
                    ST_TM:
                    begin
                        sm_next = lo_reg;
                        axis_next = 2'd0;
                        launch = 1'b1;
                        op = '{a: lo_reg,
                               b: (off_reg[0][31] ? 32'(-off_reg[0]) : 32'(off_reg[0])),
                               c: inside_reg ? {24'd0, radius_reg, 8'd0}
                                             : {24'd0, d_reg, 8'd0},
                               div: 1'b1, step: ST_F};
                    end
                    ST_F:
                    begin
                        if (off_reg[axis_reg] == '0)
                            f_w = '0;
                        else
                            f_w = sat_force(lo_reg,
                                            (!accel_reg[31]) == (!off_reg[axis_reg][31]));
                        f_next[axis_reg] = f_w;
                        rec_next[axis_reg] = sat_add(rec_reg[axis_reg], -64'(f_w));
                        if (axis_reg == 2'd2)
                        begin
                            applied_next = 1'b1;
                            state_next   = S_OUT;
                        end
                        else
                        begin
                            axis_next = axis_reg + 2'd1;
                            launch = 1'b1;
                            op = '{a: sm_reg,
                                   b: (off_reg[axis_reg + 2'd1][31]
                                       ? 32'(-off_reg[axis_reg + 2'd1])
                                       : 32'(off_reg[axis_reg + 2'd1])),
                                   c: inside_reg ? {24'd0, radius_reg, 8'd0}
                                                 : {24'd0, d_reg, 8'd0},
                                   div: 1'b1, step: ST_F};
                        end
                    end
                    ST_REC:
                    begin
                        f_next[axis_reg] = sat_force(lo_reg, rec_reg[axis_reg][63]);
                        if (axis_reg == 2'd2)
                        begin
                            applied_next = 1'b1;
                            state_next   = S_OUT;
                        end
                        else
                        begin
                            axis_next = axis_reg + 2'd1;
                            launch = 1'b1;
                            op = '{a: mom_mag_next(rec_reg[axis_reg + 2'd1]),
                                   b: {8'd0, m_reg}, c: {24'd0, msum_reg}, div: 1'b1,
                                   step: ST_REC};
                        end
                    end
                    default: state_next = S_OUT;
                endcase
            end

            S_OUT:
            begin
                if (!result_stall)
                    state_next = S_IDLE;
            end

            default: state_next = S_IDLE;
        endcase

        // start an operation on the shared unit
        if (launch)
        begin
            a_next     = op.a;
            p_next     = {64'd0, op.b};
            c_next     = op.c;
            div_next   = op.div;
            step_next  = op.step;
            cnt_next   = '0;
            state_next = S_MUL;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            step_reg    <= ST_MOM;
            cnt_reg     <= '0;
            axis_reg    <= '0;
            div_reg     <= 1'b0;
            radius_reg  <= '0;
            accel_reg   <= '0;
            msum_reg    <= '0;
            applied_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                mom_reg[i] <= '0;
                rec_reg[i] <= '0;
                f_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            cnt_reg     <= cnt_next;
            axis_reg    <= axis_next;
            div_reg     <= div_next;
            msum_reg    <= msum_next;
            applied_reg <= applied_next;
            mom_reg     <= mom_next;
            rec_reg     <= rec_next;
            f_reg       <= f_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_RADIUS: radius_reg <= cfg_data;
                    CFG_ACCEL:  accel_reg  <= $signed(cfg_data);
                    default: ;
                endcase
            end
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        c_reg      <= c_next;
        p_reg      <= p_next;
        rem_reg    <= rem_next;
        lo_reg     <= lo_next;
        bit_reg    <= bit_next;
        pos_reg    <= pos_next;
        m_reg      <= m_next;
        off_reg    <= off_next;
        d2_reg     <= d2_next;
        d_reg      <= d_next;
        inside_reg <= inside_next;
        sm_reg     <= sm_next;
    end

    // checks
    `ASSERT_IMPLY(a_div_nonzero, state_reg == S_DIV, c_reg != '0)
    `ASSERT_IMPLY(a_skip_zero, result_valid && !result.applied,
                  result.force_x == '0 && result.force_y == '0 && result.force_z == '0)
    `ASSERT_IMPLY(a_one_side, result_valid, item_stall)
    `ASSERT_NEXT(a_clear, item_valid && !item_stall && item.mode == MODE_CLEAR,
                 msum_reg == '0 && rec_reg[0] == '0 && mom_reg[0] == '0)

endmodule

>>> test/tb_sphere_gravity_force_with_recoil.sv
`timescale 1ns / 100ps

module tb_sphere_gravity_force_with_recoil;
    import sgf_pkg::*;

    localparam int SETTLE_CYCLES = 1200;
    localparam int CYCLE_LIMIT   = 8_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    item_t       item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        cfg_write = 1'b0;
    logic        cfg_index = CFG_RADIUS;
    logic [31:0] cfg_data = '0;

    // predictor copy of configuration and accumulators
    logic [31:0]        radius_q = '0;
    logic signed [63:0] accel_q = '0;
    logic signed [63:0] moment_acc [3];
    logic signed [63:0] recoil_acc [3];
    logic [63:0]        mass_total = '0;

    result_t exp_forces [$];
    int      cycles = 0;
    int      errors = 0;
    int      sent = 0;
    int      checked = 0;
    int      applied_seen = 0;
    int      hold_left = 0;
    int      burst_left = 0;
    bit      tx_idle_en = 1'b1;
    bit      rx_idle_en = 1'b1;

    always #1 clk = ~clk;

    sphere_gravity_force_with_recoil u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // arithmetic helpers of the force predictor
    function automatic logic [63:0] magn(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            return a[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        return s;
    endfunction

    function automatic logic signed [63:0] clamp_s32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // floor(a*b/c), all ones when c is zero or the quotient does not fit 64 bits
    function automatic logic [63:0] mul_div(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] c);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        if (c == 0 || p[127:64] >= c)
            return '1;
        return 64'(p / {64'b0, c});
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] bitv;
        r = '0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= r + bitv)
            begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] clip_force(input logic [63:0] m, input logic neg);
        if (m > 64'h0000_7FFF_FFFF_FFFF)
            return neg ? -64'sh8000_0000_0000 : 64'sh7FFF_FFFF_FFFF;
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // expected result of one item, updating the predictor state
    function automatic result_t predict_force(input item_t it);
        result_t            res;
        logic signed [63:0] p [3];
        logic signed [63:0] off [3];
        logic signed [63:0] fo [3];
        logic signed [63:0] com;
        logic signed [63:0] ms;
        logic [63:0]        m, q, d2, d, s, r, t, fm;
        res = '0;
        m = 64'(it.item_mass);
        ms = $signed(m);
        p[0] = it.pos_x;
        p[1] = it.pos_y;
        p[2] = it.pos_z;
        for (int i = 0; i < 3; i++)
            fo[i] = '0;
        if (it.mode == MODE_CLEAR)
        begin
            for (int i = 0; i < 3; i++)
            begin
                moment_acc[i] = '0;
                recoil_acc[i] = '0;
            end
            mass_total = '0;
            return res;
        end
        if (it.mode == MODE_ADD)
        begin
            for (int i = 0; i < 3; i++)
                moment_acc[i] = sadd(moment_acc[i], p[i] * ms);
            mass_total = mass_total + m;
            if (mass_total > 64'h00FF_FFFF_FFFF)
                mass_total = 64'h00FF_FFFF_FFFF;
            return res;
        end
        // disabled source or nothing to weigh: skipped
        if (radius_q == 0 || accel_q == 0 || mass_total == 0 || m == 0)
            return res;
        if (it.mode == MODE_PULL)
        begin
            d2 = '0;
            for (int i = 0; i < 3; i++)
            begin
                q = magn(moment_acc[i]) / mass_total;
                if (q > 64'h8000_0000)
                    q = 64'h8000_0000;
                com = moment_acc[i] < 0 ? -$signed(q) : $signed(q);
                com = clamp_s32(com);
                off[i] = clamp_s32(p[i] - com);
                d2 = d2 + magn(off[i]) * magn(off[i]);
            end
            if (d2 == 0)
                return res;
            d = int_sqrt(d2);
            s = magn(accel_q);
            r = 64'(radius_q);
            for (int i = 0; i < 3; i++)
            begin
                if (d < r)
                    fm = mul_div(s * m, magn(off[i]), r << 8);
                else
                begin
                    t = mul_div(mul_div(s, r, d), r, d);
                    fm = mul_div(t * m, magn(off[i]), d << 8);
                end
                fo[i] = off[i] == 0 ? 64'sd0 : clip_force(fm, (accel_q > 0) == (off[i] > 0));
                recoil_acc[i] = sadd(recoil_acc[i], -fo[i]);
            end
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                fm = mul_div(magn(recoil_acc[i]), m, mass_total);
                fo[i] = clip_force(fm, recoil_acc[i] < 0);
            end
        end
        res.force_x = fo[0][47:0];
        res.force_y = fo[1][47:0];
        res.force_z = fo[2][47:0];
        res.applied = 1'b1;
        return res;
    endfunction

    // random field values
    function automatic logic signed [31:0] rand_coord();
        int v;
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        v = $urandom_range(0, 26214400) - 13107200;
        return v;
    endfunction

    function automatic logic [23:0] rand_mass();
        case ($urandom_range(0, 7))
            0: return '0;
            1, 2: return 24'($urandom);
            3: return 24'hFF_FFFF;
            default: return 24'($urandom_range(1, 16 << 8));
        endcase
    endfunction

    function automatic item_t make_item(input mode_t md, input logic signed [31:0] x,
                                        input logic signed [31:0] y,
                                        input logic signed [31:0] z, input logic [23:0] m);
        item_t it;
        it.mode = md;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        it.item_mass = m;
        return it;
    endfunction

    // one input transfer, with an optional idle burst ahead of it
    task automatic send_item(input item_t it);
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            item_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        item = it;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        exp_forces.push_back(predict_force(it));
        sent++;
        @(negedge clk);
    endtask

    // sender pauses until every result is back and the block is quiet
    task automatic drain();
        item_valid = 1'b0;
        while (exp_forces.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] v);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx == CFG_RADIUS)
            radius_q = v;
        else
            accel_q = $signed(v);
    endtask

    task automatic set_source(input logic [31:0] radius, input logic [31:0] accel);
        write_reg(CFG_RADIUS, radius);
        write_reg(CFG_ACCEL, accel);
    endtask

    // ticks: clear, a few sources, several targets, recoil shares; some noise
    task automatic run_ticks(input int n);
        int          done;
        logic [23:0] masses [$];
        item_t       it;
        done = 0;
        while (done < n)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                it = make_item(mode_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                               24'($urandom));
                send_item(it);
                done++;
            end
            else
            begin
                send_item(make_item(MODE_CLEAR, rand_coord(), rand_coord(), rand_coord(),
                                    rand_mass()));
                masses.delete();
                repeat ($urandom_range(1, 4))
                begin
                    masses.push_back(rand_mass());
                    send_item(make_item(MODE_ADD, rand_coord(), rand_coord(), rand_coord(),
                                        masses[$]));
                end
                repeat ($urandom_range(1, 6))
                begin
                    send_item(make_item(MODE_PULL, rand_coord(), rand_coord(), rand_coord(),
                                        rand_mass()));
                    done++;
                end
                foreach (masses[i])
                begin
                    send_item(make_item(MODE_RECOIL, rand_coord(), rand_coord(), rand_coord(),
                                        masses[i]));
                    done++;
                end
                done += 1 + masses.size();
            end
        end
    endtask

    task automatic test_directed();
        logic signed [31:0] one;
        one = 32'sh0001_0000;
        send_item(make_item(MODE_CLEAR, 0, 0, 0, 0));
        // no source mass yet
        send_item(make_item(MODE_PULL, one, 0, 0, 24'h100));
        send_item(make_item(MODE_RECOIL, 0, 0, 0, 24'h100));
        send_item(make_item(MODE_ADD, 0, 0, 0, 24'h100));
        send_item(make_item(MODE_ADD, 2 * one, -2 * one, 0, 24'hFF_FFFF));
        // inside, outside, zero item mass, extreme position and mass
        send_item(make_item(MODE_PULL, one, 0, 0, 24'h100));
        send_item(make_item(MODE_PULL, 100 * one, 50 * one, -30 * one, 24'h100));
        send_item(make_item(MODE_PULL, 3 * one, 0, 0, 0));
        send_item(make_item(MODE_PULL, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                            24'hFF_FFFF));
        send_item(make_item(MODE_RECOIL, 0, 0, 0, 24'h100));
        send_item(make_item(MODE_RECOIL, 0, 0, 0, 24'hFF_FFFF));
        send_item(make_item(MODE_RECOIL, 0, 0, 0, 0));
        // target sitting on the center of mass
        send_item(make_item(MODE_CLEAR, 0, 0, 0, 0));
        send_item(make_item(MODE_ADD, 5 * one, 5 * one, 5 * one, 24'h100));
        send_item(make_item(MODE_PULL, 5 * one, 5 * one, 5 * one, 24'h100));
        send_item(make_item(MODE_ADD, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                            24'hFF_FFFF));
        drain();
        set_source(32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_item(make_item(MODE_PULL, 7 * one, -one, one, 24'h100));
        drain();
        // repelling source with the smallest radius
        set_source(32'h0000_0001, 32'h8000_0000);
        send_item(make_item(MODE_PULL, 7 * one, -one, one, 24'h100));
        send_item(make_item(MODE_RECOIL, 0, 0, 0, 24'h100));
        drain();
        // disabled sources
        set_source(32'h000A_0000, 32'h0000_0000);
        send_item(make_item(MODE_PULL, 7 * one, -one, one, 24'h100));
        drain();
        set_source(32'h0000_0000, 32'h0009_CCCD);
        send_item(make_item(MODE_PULL, 7 * one, -one, one, 24'h100));
        drain();
    endtask

    // receiver holds off long enough that the block backs up onto its input
    task automatic test_long_holdoff();
        drain();
        set_source(32'h000A_0000, 32'h0009_CCCD);
        hold_left = 3000;
        send_item(make_item(MODE_CLEAR, 0, 0, 0, 0));
        send_item(make_item(MODE_ADD, 32'sh0001_0000, 0, 0, 24'h200));
        repeat (4)
            send_item(make_item(MODE_PULL, rand_coord(), rand_coord(), rand_coord(),
                                rand_mass()));
        send_item(make_item(MODE_RECOIL, 0, 0, 0, 24'h200));
        drain();
    endtask

    task automatic test_phase(input logic [31:0] radius, input logic [31:0] accel,
                              input int n, input bit idle);
        drain();
        tx_idle_en = idle;
        rx_idle_en = idle;
        set_source(radius, accel);
        run_ticks(n / 2);
        drain();
        run_ticks(n - n / 2);
    endtask

    // result side stall: long hold-offs first, then random bursts
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_stall = 1'b1;
        end
        else if (burst_left > 0)
        begin
            burst_left = burst_left - 1;
            result_stall = 1'b1;
        end
        else if (rx_idle_en && $urandom_range(0, 7) == 0)
        begin
            burst_left = $urandom_range(0, 4);
            result_stall = 1'b1;
        end
        else
            result_stall = 1'b0;
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (exp_forces.size() == 0)
            begin
                $error("result transfer with nothing expected");
                errors++;
            end
            else
            begin
                want = exp_forces.pop_front();
                checked++;
                if (result.applied)
                    applied_seen++;
                if (result.force_x !== want.force_x)
                begin
                    $error("force_x expected %0d actual %0d", want.force_x, result.force_x);
                    errors++;
                end
                if (result.force_y !== want.force_y)
                begin
                    $error("force_y expected %0d actual %0d", want.force_y, result.force_y);
                    errors++;
                end
                if (result.force_z !== want.force_z)
                begin
                    $error("force_z expected %0d actual %0d", want.force_z, result.force_z);
                    errors++;
                end
                if (result.applied !== want.applied)
                begin
                    $error("applied expected %0d actual %0d", want.applied, result.applied);
                    errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("sphere_gravity_force_with_recoil verification failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < 3; i++)
        begin
            moment_acc[i] = '0;
            recoil_acc[i] = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        set_source(32'h000A_0000, 32'h0009_CCCD);
        test_directed();
        test_long_holdoff();
        test_phase(32'h000A_0000, 32'h0009_CCCD, 300, 1'b1);
        test_phase(32'hFFFF_FFFF, 32'h7FFF_FFFF, 250, 1'b1);
        test_phase(32'h0000_0001, 32'h8000_0000, 250, 1'b1);
        test_phase($urandom, $urandom, 300, 1'b1);
        test_phase(32'h0032_0000, 32'hFFFD_0000, 300, 1'b1);
        test_phase($urandom_range(1, 200) << 16, $urandom, 400, 1'b0);
        drain();
        $display("covered %0d input transfers over several source settings", sent);
        $display("checked %0d results, %0d of them with a force applied", checked,
                 applied_seen);
        if (errors == 0)
            $display("sphere_gravity_force_with_recoil verification clean");
        else
            $display("sphere_gravity_force_with_recoil verification failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/sgf_pkg.sv
rtl/core/sphere_gravity_force_with_recoil.sv
test/tb_sphere_gravity_force_with_recoil.sv
